[rtl/gb5_pkg.sv]
// Shared types, constants and the kernel weight map of the 5x5 Gaussian blur.
package gb5_pkg;

    localparam int PIXW    = 24;
    localparam int CHW     = 8;
    localparam int NCH     = 3;
    localparam int WIN     = 5;
    localparam int NTAP    = WIN * WIN;
    localparam int LINES   = 4;
    localparam int NGRP    = 6;
    localparam int GSW     = 11;
    localparam int WTW     = 16;
    localparam int PRW     = GSW + WTW;
    localparam int ACCW    = 30;
    localparam int DIMW    = 13;
    localparam int FRACW   = 16;
    localparam int IDXW    = 3;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int MIN_DIM       = 5;
    localparam int MAX_HEIGHT    = 4096;

    // Weight groups, in the order of the configuration registers.
    localparam logic [2:0] GRP_CORNER     = 3'd0;
    localparam logic [2:0] GRP_OUTER_NEAR = 3'd1;
    localparam logic [2:0] GRP_OUTER_AXIS = 3'd2;
    localparam logic [2:0] GRP_INNER_DIAG = 3'd3;
    localparam logic [2:0] GRP_INNER_AXIS = 3'd4;
    localparam logic [2:0] GRP_CENTRE     = 3'd5;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [IDXW-1:0] {
        REG_WIDTH       = 3'd0,
        REG_HEIGHT      = 3'd1,
        REG_W_CORNER    = 3'd2,
        REG_W_OUTER_NR  = 3'd3,
        REG_W_OUTER_AX  = 3'd4,
        REG_W_INNER_DG  = 3'd5,
        REG_W_INNER_AX  = 3'd6,
        REG_W_CENTRE    = 3'd7
    } t_reg_idx;

    localparam logic [DIMW-1:0] RST_WIDTH  = 13'd4096;
    localparam logic [DIMW-1:0] RST_HEIGHT = 13'd2304;
    localparam logic [WTW-1:0]  RST_W_CORNER    = 16'd945;
    localparam logic [WTW-1:0]  RST_W_OUTER_NR  = 16'd1841;
    localparam logic [WTW-1:0]  RST_W_OUTER_AX  = 16'd2299;
    localparam logic [WTW-1:0]  RST_W_INNER_DG  = 16'd3585;
    localparam logic [WTW-1:0]  RST_W_INNER_AX  = 16'd4477;
    localparam logic [WTW-1:0]  RST_W_CENTRE    = 16'd5591;

    typedef logic [PIXW-1:0]               t_pix;
    typedef logic [NTAP-1:0][PIXW-1:0]     t_win;
    typedef logic [LINES-1:0][PIXW-1:0]    t_lines;
    typedef logic [NGRP-1:0][WTW-1:0]      t_weights;
    typedef logic [NCH-1:0][CHW-1:0]       t_rgb;

    // One step of the window: a new column shifted in on the right.
    typedef struct packed {
        t_pix             pix;
        logic [LINES-1:0] mask;
        logic [1:0]       base;
        logic             clr;
        logic             emit;
        logic             last;
    } t_step;

    // Weight group of window tap (ky, kx).
    function automatic logic [2:0] weight_grp(input int ky, input int kx);
        int a;
        int b;
        int t;
        logic [2:0] g;
        a = (ky >= 2) ? ky - 2 : 2 - ky;
        b = (kx >= 2) ? kx - 2 : 2 - kx;
        if (a < b) begin
            t = a;
            a = b;
            b = t;
        end
        if (a == 0) begin
            g = GRP_CENTRE;
        end else if (a == 1) begin
            g = (b == 0) ? GRP_INNER_AXIS : GRP_INNER_DIAG;
        end else if (b == 0) begin
            g = GRP_OUTER_AXIS;
        end else if (b == 1) begin
            g = GRP_OUTER_NEAR;
        end else begin
            g = GRP_CORNER;
        end
        return g;
    endfunction

endpackage

[rtl/gb5_line_bank.sv]
// One row bank of the line store: one port, read of the old data before the write.
module gb5_line_bank
    import gb5_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  t_pix                     i_wdata,
    output t_pix                     o_rdata
);

    t_pix r_mem [DEPTH];
    t_pix r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/gb5_ctrl.sv]
// Position counters and step sequencer: pixels, row flushes and drain rows.
module gb5_ctrl
    import gb5_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int XW = AW + 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [XW-1:0]   i_width,
    input  logic [DIMW-1:0] i_height,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_opcode,
    input  t_pix            i_pix,
    input  logic            i_s1_ready,
    output logic            o_issue,
    output t_step           o_step,
    output logic [AW-1:0]   o_addr,
    output logic [LINES-1:0] o_we
);

    logic [XW-1:0]   r_col, n_col;
    logic [DIMW-1:0] r_row, n_row;
    logic [1:0]      r_flush, n_flush;

    logic            pix_phase;
    logic            internal;
    logic            acc;
    logic [XW-1:0]   x;
    logic [XW-1:0]   wm1;
    logic            last_row;

    always_comb begin
        wm1        = i_width - XW'(1);
        pix_phase  = r_row < i_height;
        internal   = (r_flush != 2'd0) || (!pix_phase && r_col < XW'(2));
        o_in_ready = i_s1_ready && !internal;
        acc        = i_in_valid && o_in_ready;
        x          = (r_col < wm1) ? r_col : wm1;
        last_row   = {1'b0, r_row} >= ({1'b0, i_height} + 14'd1);

        o_issue       = 1'b0;
        o_step.pix    = '0;
        o_step.mask   = '1;
        o_step.base   = r_row[1:0];
        o_step.clr    = 1'b0;
        o_step.emit   = 1'b1;
        o_step.last   = 1'b0;
        o_addr        = r_col[AW-1:0];
        o_we          = '0;
        n_col         = r_col;
        n_row         = r_row;
        n_flush       = r_flush;

        if (r_flush != 2'd0) begin
            // Zero columns close the windows of the last two outputs of a row.
            o_issue = i_s1_ready;
            if (o_issue) begin
                n_flush = r_flush - 2'd1;
            end
        end else if (!pix_phase) begin
            // Drain rows: rows at or below the frame end read as zero.
            o_issue     = (r_col < XW'(2)) ? i_s1_ready : (acc && i_opcode == OP_DRAIN);
            o_step.clr  = r_col == '0;
            o_step.emit = r_col >= XW'(2);
            o_step.last = last_row && (r_col == i_width + XW'(1));
            for (int ky = 0; ky < LINES; ky++) begin
                o_step.mask[ky] = (r_col >= i_width) ||
                    (({1'b0, r_row} + 14'(ky)) >= ({1'b0, i_height} + 14'd4));
            end
            if (o_issue) begin
                if (r_col == i_width + XW'(1)) begin
                    n_col = '0;
                    n_row = last_row ? '0 : r_row + DIMW'(1);
                end else begin
                    n_col = r_col + XW'(1);
                end
            end
        end else begin
            o_issue     = acc && i_opcode == OP_PIXEL;
            o_addr      = x[AW-1:0];
            o_step.pix  = i_pix;
            o_step.clr  = x == '0;
            o_step.emit = (x >= XW'(2)) && (r_row >= DIMW'(2));
            for (int ky = 0; ky < LINES; ky++) begin
                o_step.mask[ky] = ({1'b0, r_row} + 14'(ky)) < 14'd4;
            end
            if (o_issue) begin
                o_we[r_row[1:0]] = 1'b1;
                if (x == wm1) begin
                    n_col   = '0;
                    n_row   = r_row + DIMW'(1);
                    n_flush = (r_row >= DIMW'(2)) ? 2'd2 : 2'd0;
                end else begin
                    n_col = x + XW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_flush <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_flush <= n_flush;
        end
    end

endmodule

[rtl/gb5_window.sv]
// Step register and 5x5 window: shifts in one column per step.
module gb5_window
    import gb5_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_issue,
    input  t_step  i_step,
    input  t_lines i_rdata,
    output logic   o_s1_ready,
    input  logic   i_s3_ready,
    output logic   o_s2_valid,
    output logic   o_s2_last,
    output t_win   o_win
);

    logic  r_s1_v;
    t_step r_s1;
    logic  r_s2_v, n_s2_v;
    logic  r_s2_last;
    t_win  r_win, n_win, base_win;
    logic  s2_ready;
    logic  s1_fire;
    logic [WIN-1:0][PIXW-1:0] col;

    always_comb begin
        s2_ready   = !r_s2_v || i_s3_ready;
        o_s1_ready = !r_s1_v || s2_ready;
        s1_fire    = r_s1_v && s2_ready;
        n_s2_v     = s2_ready ? (s1_fire && r_s1.emit) : r_s2_v;

        for (int ky = 0; ky < LINES; ky++) begin
            col[ky] = r_s1.mask[ky] ? '0 : i_rdata[2'(r_s1.base + 2'(ky))];
        end
        col[WIN-1] = r_s1.pix;

        base_win = r_s1.clr ? '0 : r_win;
        for (int ky = 0; ky < WIN; ky++) begin
            for (int kx = 0; kx < WIN; kx++) begin
                n_win[ky*WIN+kx] = (kx < WIN - 1) ? base_win[ky*WIN+kx+1] : col[ky];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (o_s1_ready) begin
                r_s1_v <= i_issue;
            end
            r_s2_v <= n_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_ready && i_issue) begin
            r_s1 <= i_step;
        end
        if (s1_fire) begin
            r_win <= n_win;
        end
        if (s2_ready && s1_fire) begin
            r_s2_last <= r_s1.last;
        end
    end

    assign o_s2_valid = r_s2_v;
    assign o_s2_last  = r_s2_last;
    assign o_win      = r_win;

endmodule

[rtl/gb5_filter.sv]
// Kernel arithmetic: group sums, six products per color, sum, shift, saturate.
module gb5_filter
    import gb5_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_weights i_weights,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_win     i_win,
    input  logic     i_last,
    output logic     o_valid,
    input  logic     i_ready,
    output t_rgb     o_rgb,
    output logic     o_last
);

    logic r_a_v, r_b_v, r_c_v;
    logic r_a_last, r_b_last, r_c_last;
    logic a_ready, b_ready, c_ready;

    logic [NCH-1:0][NGRP-1:0][GSW-1:0] gsum, r_gsum;
    logic [NCH-1:0][NGRP-1:0][PRW-1:0] r_prod;
    logic [NCH-1:0][ACCW-1:0]          total;
    logic [NCH-1:0][ACCW-FRACW-1:0]    shifted;
    t_rgb                              sat, r_rgb;

    always_comb begin
        c_ready = !r_c_v || i_ready;
        b_ready = !r_b_v || c_ready;
        a_ready = !r_a_v || b_ready;
        o_ready = a_ready;

        gsum = '0;
        for (int ch = 0; ch < NCH; ch++) begin
            for (int t = 0; t < NTAP; t++) begin
                gsum[ch][weight_grp(t / WIN, t % WIN)] =
                    gsum[ch][weight_grp(t / WIN, t % WIN)] +
                    GSW'(i_win[t][CHW*ch +: CHW]);
            end
        end

        for (int ch = 0; ch < NCH; ch++) begin
            total[ch] = '0;
            for (int g = 0; g < NGRP; g++) begin
                total[ch] = total[ch] + ACCW'(r_prod[ch][g]);
            end
            shifted[ch] = total[ch][ACCW-1:FRACW];
            sat[ch] = (shifted[ch] > (ACCW-FRACW)'(255)) ? 8'hFF : shifted[ch][CHW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (a_ready) r_a_v <= i_valid;
            if (b_ready) r_b_v <= r_a_v;
            if (c_ready) r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_gsum   <= gsum;
            r_a_last <= i_last;
        end
        if (b_ready && r_a_v) begin
            for (int ch = 0; ch < NCH; ch++) begin
                for (int g = 0; g < NGRP; g++) begin
                    r_prod[ch][g] <= PRW'(r_gsum[ch][g]) * PRW'(i_weights[g]);
                end
            end
            r_b_last <= r_a_last;
        end
        if (c_ready && r_b_v) begin
            r_rgb    <= sat;
            r_c_last <= r_b_last;
        end
    end

    assign o_valid = r_c_v;
    assign o_rgb   = r_rgb;
    assign o_last  = r_c_last;

endmodule

[rtl/gaussian_blur_5x5_rgb.sv]
// Top level of the 5x5 Gaussian blur for a BGR pixel stream.
//
//   Channel  Signals                                   Direction  Word
//   in       i_in_valid / o_in_ready, opcode + BGR     sink       one pixel or drain tick
//   out      o_out_valid / i_out_ready, BGR + last     source     one filtered pixel
//   cfg      i_cfg_valid / o_cfg_ready, index + data   sink       one register write
//
// A pixel word is accepted every cycle while nothing stalls. From the third row on, each
// row end shifts two zero columns into the window on internal steps to release its last
// two outputs. After the frame, each of the two drain rows starts with internal steps at
// columns 0 and 1 that preload the window from the line store, then takes one drain word
// per cycle while nothing stalls. A result passes the step, window, group-sum, product
// and output registers after the word that completes its window. Reset clears the counters
// and pipeline valid bits and loads the default registers; the line store needs no clearing
// pass. An output stall holds each full stage; the input stops once the stage ahead fills.
module gaussian_blur_5x5_rgb
    import gb5_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_opcode,
    input  logic [CHW-1:0]  i_blue_in,
    input  logic [CHW-1:0]  i_green_in,
    input  logic [CHW-1:0]  i_red_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [CHW-1:0]  o_blue_out,
    output logic [CHW-1:0]  o_green_out,
    output logic [CHW-1:0]  o_red_out,
    output logic            o_frame_last,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [IDXW-1:0] i_cfg_index,
    input  logic [WTW-1:0]  i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int XW = AW + 1;

    // Configuration registers; the size is clamped to the legal range before use.
    logic [DIMW-1:0] r_width, r_height;
    t_weights        r_weights;
    logic [XW-1:0]   eff_width;
    logic [DIMW-1:0] eff_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RST_WIDTH;
            r_height  <= RST_HEIGHT;
            r_weights <= {RST_W_CENTRE, RST_W_INNER_AX, RST_W_INNER_DG,
                          RST_W_OUTER_AX, RST_W_OUTER_NR, RST_W_CORNER};
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_WIDTH:      r_width <= i_cfg_data[DIMW-1:0];
                REG_HEIGHT:     r_height <= i_cfg_data[DIMW-1:0];
                REG_W_CORNER:   r_weights[GRP_CORNER] <= i_cfg_data;
                REG_W_OUTER_NR: r_weights[GRP_OUTER_NEAR] <= i_cfg_data;
                REG_W_OUTER_AX: r_weights[GRP_OUTER_AXIS] <= i_cfg_data;
                REG_W_INNER_DG: r_weights[GRP_INNER_DIAG] <= i_cfg_data;
                REG_W_INNER_AX: r_weights[GRP_INNER_AXIS] <= i_cfg_data;
                REG_W_CENTRE:   r_weights[GRP_CENTRE] <= i_cfg_data;
                default:        r_width <= r_width;
            endcase
        end
    end

    always_comb begin
        if (r_width < DIMW'(MIN_DIM)) begin
            eff_width = XW'(MIN_DIM);
        end else if ({1'b0, r_width} > 14'(MAX_WIDTH)) begin
            eff_width = XW'(MAX_WIDTH);
        end else begin
            eff_width = XW'(r_width);
        end
        if (r_height < DIMW'(MIN_DIM)) begin
            eff_height = DIMW'(MIN_DIM);
        end else if (r_height > DIMW'(MAX_HEIGHT)) begin
            eff_height = DIMW'(MAX_HEIGHT);
        end else begin
            eff_height = r_height;
        end
    end

    // The sequencer turns words into window steps and drives the line store.
    logic             issue;
    t_step            step;
    logic [AW-1:0]    addr;
    logic [LINES-1:0] we;
    logic             s1_ready;
    t_lines           rdata;

    gb5_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_width    (eff_width),
        .i_height   (eff_height),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_opcode   (i_opcode),
        .i_pix      ({i_red_in, i_green_in, i_blue_in}),
        .i_s1_ready (s1_ready),
        .o_issue    (issue),
        .o_step     (step),
        .o_addr     (addr),
        .o_we       (we)
    );

    // Four row banks hold the last four rows; row r lives in bank r mod 4.
    for (genvar b = 0; b < LINES; b++) begin : g_bank
        gb5_line_bank #(
            .DEPTH (MAX_WIDTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_en    (issue),
            .i_we    (we[b]),
            .i_addr  (addr),
            .i_wdata (step.pix),
            .o_rdata (rdata[b])
        );
    end

    logic s2_valid, s2_last, s3_ready;
    t_win win;

    gb5_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_issue    (issue),
        .i_step     (step),
        .i_rdata    (rdata),
        .o_s1_ready (s1_ready),
        .i_s3_ready (s3_ready),
        .o_s2_valid (s2_valid),
        .o_s2_last  (s2_last),
        .o_win      (win)
    );

    t_rgb rgb;

    gb5_filter u_filter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_weights (r_weights),
        .i_valid   (s2_valid),
        .o_ready   (s3_ready),
        .i_win     (win),
        .i_last    (s2_last),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_rgb     (rgb),
        .o_last    (o_frame_last)
    );

    assign o_blue_out  = rgb[0];
    assign o_green_out = rgb[1];
    assign o_red_out   = rgb[2];

endmodule
